// ===== src/ssq_pkg.sv =====
package ssq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = 5;
  localparam int ID_W        = 16;
  localparam int TIME_W      = 12;
  localparam int KEY_W       = 13;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the input word
    logic commit;  // update the queue and load the output word
  } ssq_cmd_t;

endpackage

// ===== src/ssq_ctrl.sv =====
module ssq_ctrl import ssq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ssq_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Output register can take a new word when empty or being drained
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.commit = (state_r == S_EXEC) && out_free;

  // Next state and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/ssq_datapath.sv =====
module ssq_datapath import ssq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ssq_cmd_t                cmd,
  input  logic                    in_op,
  input  logic [ID_W-1:0]         in_customer_id,
  input  logic [TIME_W-1:0]       in_patience,
  input  logic [TIME_W-1:0]       in_prep_time,
  output logic [1:0]              out_status,
  output logic                    out_head_valid,
  output logic [ID_W-1:0]         out_head_id,
  output logic signed [KEY_W-1:0] out_head_slack,
  output logic [CNT_W-1:0]        out_count
);

  // Captured input word
  logic                    op_r;
  logic [ID_W-1:0]         id_r;
  logic signed [KEY_W-1:0] key_r;

  // Queue cells
  logic [ID_W-1:0]         ids_r   [QUEUE_DEPTH];
  logic signed [KEY_W-1:0] slacks_r[QUEUE_DEPTH];
  logic [ID_W-1:0]         ids_nxt   [QUEUE_DEPTH];
  logic signed [KEY_W-1:0] slacks_nxt[QUEUE_DEPTH];
  logic [CNT_W-1:0]        count_r, count_nxt;

  // Output word
  logic [1:0]              status_r;
  logic                    head_valid_r;
  logic [ID_W-1:0]         head_id_r;
  logic signed [KEY_W-1:0] head_slack_r;
  logic [CNT_W-1:0]        out_count_r;

  logic [QUEUE_DEPTH-1:0] lt;       // held and slack below new key
  logic [QUEUE_DEPTH-1:0] match;    // held and id equal
  logic [QUEUE_DEPTH-1:0] past_hit; // at or after the first match
  logic                   full;
  logic                   found;
  status_t                status;

  // Per-cell compares, all in parallel
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      lt[i]    = (CNT_W'(i) < count_r) && (slacks_r[i] < key_r);
      match[i] = (CNT_W'(i) < count_r) && (ids_r[i] == id_r);
    end
    past_hit[0] = match[0];
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      past_hit[i] = past_hit[i-1] | match[i];
    end
  end

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign found = |match;

  // Shift network for the next cell contents
  always_comb begin
    count_nxt = count_r;
    status    = ST_DONE;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ids_nxt[i]    = ids_r[i];
      slacks_nxt[i] = slacks_r[i];
    end
    if (op_r == OP_INSERT) begin
      if (full) begin
        status = ST_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (!lt[i]) begin
            if (i == 0) begin
              ids_nxt[i]    = id_r;
              slacks_nxt[i] = key_r;
            end else if (lt[i-1]) begin
              ids_nxt[i]    = id_r;
              slacks_nxt[i] = key_r;
            end else begin
              ids_nxt[i]    = ids_r[i-1];
              slacks_nxt[i] = slacks_r[i-1];
            end
          end
        end
      end
    end else begin
      if (!found) begin
        status = ST_NOT_FOUND;
      end else begin
        count_nxt = count_r - 1'b1;
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          if (past_hit[i]) begin
            ids_nxt[i]    = ids_r[i+1];
            slacks_nxt[i] = slacks_r[i+1];
          end
        end
      end
    end
  end

  // Input capture; slack is patience minus prep time
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      id_r  <= in_customer_id;
      key_r <= $signed({1'b0, in_patience}) - $signed({1'b0, in_prep_time});
    end
  end

  // Queue cells and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        ids_r[i]    <= ids_nxt[i];
        slacks_r[i] <= slacks_nxt[i];
      end
      status_r     <= status;
      head_valid_r <= (count_nxt != '0);
      head_id_r    <= (count_nxt != '0) ? ids_nxt[0] : '0;
      head_slack_r <= (count_nxt != '0) ? slacks_nxt[0] : '0;
      out_count_r  <= count_nxt;
    end
  end

  assign out_status     = status_r;
  assign out_head_valid = head_valid_r;
  assign out_head_id    = head_id_r;
  assign out_head_slack = head_slack_r;
  assign out_count      = out_count_r;

endmodule

// ===== src/slack_sorted_priority_queue_unit.sv =====
// Slack-sorted priority queue of up to 16 entries (id, slack key), where
// slack = patience - prep_time, kept in ascending order of slack.
// Input channel (in_valid/in_stall): one word per operation, insert
// (in_op = 0) or remove by id (in_op = 1). Result channel
// (out_valid/out_stall): one word per operation with status, head entry
// and count as they stand after the operation.
// The result is registered: out_valid rises after the operation commits
// in S_EXEC, which waits while a pending result is stalled. The
// controller takes a word in S_IDLE, then runs the parallel compare and
// shift over all cells in S_EXEC; no new word is taken until it commits.
// The output register holds a finished result, so the next word is taken
// while the result waits; if the receiver still stalls when that second
// operation is ready to commit, it waits and in_stall stays high.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; cell contents are left as they are and never read until written.
module slack_sorted_priority_queue_unit import ssq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_op,
  input  logic [ID_W-1:0]         in_customer_id,
  input  logic [TIME_W-1:0]       in_patience,
  input  logic [TIME_W-1:0]       in_prep_time,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic                    out_head_valid,
  output logic [ID_W-1:0]         out_head_id,
  output logic signed [KEY_W-1:0] out_head_slack,
  output logic [CNT_W-1:0]        out_count
);

  ssq_cmd_t cmd;

  ssq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ssq_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_op          (in_op),
    .in_customer_id (in_customer_id),
    .in_patience    (in_patience),
    .in_prep_time   (in_prep_time),
    .out_status     (out_status),
    .out_head_valid (out_head_valid),
    .out_head_id    (out_head_id),
    .out_head_slack (out_head_slack),
    .out_count      (out_count)
  );

endmodule
